>>> design/sync_id_affinity_dispatcher_unit_macros.svh
// Assertion macros for the flow-affinity dispatcher checker.
`ifndef SYNC_ID_AFFINITY_DISPATCHER_UNIT_MACROS_SVH
`define SYNC_ID_AFFINITY_DISPATCHER_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define SIDU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dispatcher check failed");

// Next-cycle implication, held off while reset is asserted.
`define SIDU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dispatcher check failed");

`endif

>>> design/sidu_pkg.sv
// Types and constants of the flow-affinity dispatcher.
`timescale 1ns / 1ps
package sidu_pkg;

  localparam int MAX_WORKERS   = 64;
  localparam int BACKLOG_DEPTH = 16;
  localparam int COUNT_BITS    = 16;
  localparam int RESULT_CAP    = 16;

  localparam int WADDR_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WORKERS + 1);
  localparam int BL_AW   = $clog2(BACKLOG_DEPTH);
  localparam int BL_FW   = BL_AW + 1;
  localparam int RCNT_W  = $clog2(RESULT_CAP + 1);

  localparam int IN_DATA_W  = 120;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 120;
  localparam int OUT_USER_W = 4;
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 7;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_WORKER_COUNT = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_ENABLED      = 1'b1;

  // Result status codes
  localparam logic [2:0] STS_DISPATCHED = 3'd0;
  localparam logic [2:0] STS_QUEUED     = 3'd1;
  localparam logic [2:0] STS_FULL       = 3'd2;
  localparam logic [2:0] STS_NONE       = 3'd3;
  localparam logic [2:0] STS_ERROR      = 3'd4;

  // Input opcodes
  localparam logic OP_REQUEST    = 1'b0;
  localparam logic OP_COMPLETION = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ERR, ST_CRD, ST_CCHK, ST_SCAN, ST_DECIDE, ST_DRAIN, ST_FIN
  } state_t;

  typedef enum logic [1:0] {PK_WORKER, PK_FULL, PK_NONE} pick_t;

  typedef struct packed {
    logic [31:0]           flow;
    logic [COUNT_BITS-1:0] cnt;
  } wk_entry_t;

  typedef struct packed {
    logic [31:0] flow;
    logic        kind;
    logic [15:0] code;
    logic [31:0] ctx;
    logic [31:0] tok;
  } bl_entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  worker;
    logic [31:0] flow;
    logic        kind;
    logic [15:0] code;
    logic [31:0] ctx;
    logic [31:0] tok;
    logic        last;
  } res_t;

endpackage

>>> design/sync_id_affinity_dispatcher_unit.sv
// Flow-affinity dispatcher: binds requests to workers, keeps a backlog, drains on completion.
`timescale 1ns / 1ps
// Usage
//   in_*  : one transfer per item. tuser = {request_kind, opcode}; opcode 0 is a
//           new request, opcode 1 a completion from worker_index.
//   out_* : one or more results per item, tlast on the final one. A request gives
//           exactly one result (dispatched, queued, rejected full or error).
//           A valid completion gives up to 16 dispatches drained from the backlog
//           head, or one "nothing dispatched" result.
//   cfg_* : register writes (worker_count, enabled), user writes only while idle; not enforced.
// Timing
//   in_tready is high only in idle. Each worker lookup scans the table one entry
//   per cycle from its single read port and stops early on an affinity hit.
// Reset
//   rst_n low clears the worker table valid bits, the backlog pointers and the
//   sequencer; worker_count reads 64, enabled reads 0. No clearing pass.
// Stalls
//   One output register; while it holds a result that out_tready does not take,
//   the sequencer holds before its next result and keeps all state unchanged.
module sync_id_affinity_dispatcher_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // flow_id[31:0], worker_index[37:32], request_code[53:38], context_id[85:54],
  // token_id[117:86], zero pad[119:118]
  input  logic [sidu_pkg::IN_DATA_W-1:0]   in_tdata,
  // opcode[0], request_kind[1]
  input  logic [sidu_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // worker[5:0], out_flow_id[37:6], out_code[53:38], out_context[85:54],
  // out_token[117:86], zero pad[119:118]
  output logic [sidu_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status[2:0], out_kind[3]
  output logic [sidu_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [sidu_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [sidu_pkg::CFG_DW-1:0]      cfg_wdata
);
  import sidu_pkg::*;

  state_t state_r, state_nxt;

  // Config registers
  logic [CFG_DW-1:0] worker_count_r;
  logic              enabled_r;

  // Captured item
  logic        op_r;
  logic [31:0] flow_r;
  logic [5:0]  widx_r;
  logic        kind_r;
  logic [15:0] code_r;
  logic [31:0] ctx_r;
  logic [31:0] tok_r;

  // Worker table
  wk_entry_t            wk_mem [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] wk_vld_r;
  wk_entry_t            wk_q_r;
  logic                 wk_qv_r;
  logic [WADDR_W-1:0]   wk_raddr;
  logic                 wk_we;
  logic [WADDR_W-1:0]   wk_waddr;
  wk_entry_t            wk_wdata;
  logic [COUNT_BITS-1:0] q_cnt;
  logic [31:0]          q_flow;

  // Backlog
  bl_entry_t          bl_mem [BACKLOG_DEPTH];
  bl_entry_t          bl_q_r;
  logic [BL_AW-1:0]   head_r, head_nxt;
  logic [BL_FW-1:0]   fill_r, fill_nxt;
  logic [BL_FW-1:0]   tail_sum;
  logic [BL_AW-1:0]   tail;
  logic               bl_we;
  bl_entry_t          bl_wdata;

  // Scan unit
  logic [WCNT_W-1:0]  active;
  logic [WCNT_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic               stage_r, stage_nxt;
  logic [WADDR_W-1:0] stage_idx_r;
  logic               free_found_r, free_found_nxt;
  logic [WADDR_W-1:0] free_idx_r, free_idx_nxt;
  logic               issue, hit, done;
  logic [31:0]        target;
  pick_t              pick_r, pick_nxt;
  logic [WADDR_W-1:0] pick_w_r, pick_w_nxt;
  logic [COUNT_BITS-1:0] pick_cnt_r, pick_cnt_nxt;

  // Drain bookkeeping
  res_t               pend_r, pend_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [RCNT_W-1:0]  n_r, n_nxt;

  // Output register
  res_t out_r;
  logic out_tvalid_r;
  logic out_free;
  logic load;
  res_t res;

  logic       in_xfer;
  logic [COUNT_BITS-1:0] dec_cnt;

  function automatic res_t mk_status(input logic [2:0] sts);
    res_t r;
    r = '0;
    r.status = sts;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_disp(input logic [WADDR_W-1:0] w, input bl_entry_t e);
    res_t r;
    r = '0;
    r.status = STS_DISPATCHED;
    r.worker = 6'(w);
    r.flow   = e.flow;
    r.kind   = e.kind;
    r.code   = e.code;
    r.ctx    = e.kind ? e.ctx : 32'd0;
    r.tok    = e.kind ? e.tok : 32'd0;
    return r;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign active = (worker_count_r > CFG_DW'(MAX_WORKERS)) ? WCNT_W'(MAX_WORKERS)
                                                        : WCNT_W'(worker_count_r);

  assign q_cnt  = wk_qv_r ? wk_q_r.cnt  : '0;
  assign q_flow = wk_qv_r ? wk_q_r.flow : 32'd0;
  assign dec_cnt = q_cnt - COUNT_BITS'(1);

  assign tail_sum = BL_FW'(head_r) + fill_r;
  assign tail = (tail_sum >= BL_FW'(BACKLOG_DEPTH)) ? BL_AW'(tail_sum - BL_FW'(BACKLOG_DEPTH))
                                                   : BL_AW'(tail_sum);

  assign target = (op_r == OP_COMPLETION) ? bl_q_r.flow : flow_r;

  // Scan compare on the registered read
  assign issue = (scan_addr_r < active);
  assign hit   = stage_r && (q_cnt != '0) && (q_flow == target);
  assign done  = hit || (!stage_r && !issue);

  assign wk_raddr = (state_r == ST_SCAN) ? scan_addr_r[WADDR_W-1:0] : widx_r[WADDR_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser[0] == OP_COMPLETION) state_nxt = ST_CRD;
          else if (in_tdata[31:0] == 32'd0) state_nxt = ST_ERR;
          else                              state_nxt = ST_SCAN;
        end
      end
      ST_ERR:  if (out_free) state_nxt = ST_IDLE;
      ST_CRD:  state_nxt = ST_CCHK;
      ST_CCHK: begin
        if (!enabled_r || ({1'b0, widx_r} >= 7'(active)) || q_cnt == '0) state_nxt = ST_ERR;
        else state_nxt = ST_DRAIN;
      end
      ST_SCAN: if (done) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (op_r == OP_REQUEST) begin
          if (out_free) state_nxt = ST_IDLE;
        end else if (pick_r != PK_WORKER) begin
          state_nxt = ST_FIN;
        end else if (!pend_vld_r || out_free) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (fill_r == '0 || n_r == RCNT_W'(RESULT_CAP)) state_nxt = ST_FIN;
        else state_nxt = ST_SCAN;
      end
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    load = 1'b0;
    res = mk_status(STS_ERROR);
    wk_we = 1'b0;
    wk_waddr = pick_w_r;
    wk_wdata = '{flow: target, cnt: pick_cnt_r + COUNT_BITS'(1)};
    bl_we = 1'b0;
    bl_wdata = '{flow: flow_r, kind: kind_r, code: code_r, ctx: ctx_r, tok: tok_r};
    head_nxt = head_r;
    fill_nxt = fill_r;
    pend_nxt = pend_r;
    pend_vld_nxt = pend_vld_r;
    n_nxt = n_r;
    scan_addr_nxt = scan_addr_r;
    stage_nxt = 1'b0;
    free_found_nxt = free_found_r;
    free_idx_nxt = free_idx_r;
    pick_nxt = pick_r;
    pick_w_nxt = pick_w_r;
    pick_cnt_nxt = pick_cnt_r;

    unique case (state_r)
      ST_ERR: load = out_free;
      ST_CCHK: begin
        if (state_nxt == ST_DRAIN) begin
          wk_we = 1'b1;
          wk_waddr = widx_r[WADDR_W-1:0];
          wk_wdata = '{flow: (dec_cnt == '0) ? 32'd0 : q_flow, cnt: dec_cnt};
          n_nxt = '0;
          pend_vld_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue && !hit) begin
          scan_addr_nxt = scan_addr_r + WCNT_W'(1);
          stage_nxt = 1'b1;
        end
        if (stage_r && q_cnt == '0 && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt = stage_idx_r;
        end
        if (hit) begin
          pick_nxt = (q_cnt == COUNT_MAX) ? PK_FULL : PK_WORKER;
          pick_w_nxt = stage_idx_r;
          pick_cnt_nxt = q_cnt;
        end else if (done) begin
          pick_nxt = free_found_r ? PK_WORKER : PK_NONE;
          pick_w_nxt = free_idx_r;
          pick_cnt_nxt = '0;
        end
      end
      ST_DECIDE: begin
        if (op_r == OP_REQUEST) begin
          if (out_free) begin
            load = 1'b1;
            if (pick_r == PK_WORKER) begin
              wk_we = 1'b1;
              res = mk_disp(pick_w_r, bl_wdata);
              res.last = 1'b1;
            end else if (pick_r == PK_FULL || fill_r >= BL_FW'(BACKLOG_DEPTH)) begin
              res = mk_status(STS_FULL);
            end else begin
              bl_we = 1'b1;
              fill_nxt = fill_r + BL_FW'(1);
              res = mk_status(STS_QUEUED);
            end
          end
        end else if (state_nxt == ST_DRAIN) begin
          wk_we = 1'b1;
          load = pend_vld_r;
          res = pend_r;
          res.last = 1'b0;
          pend_nxt = mk_disp(pick_w_r, bl_q_r);
          pend_vld_nxt = 1'b1;
          n_nxt = n_r + RCNT_W'(1);
          fill_nxt = fill_r - BL_FW'(1);
          head_nxt = (head_r == BL_AW'(BACKLOG_DEPTH - 1)) ? '0 : head_r + BL_AW'(1);
        end
      end
      ST_FIN: begin
        load = out_free;
        res = pend_r;
        res.last = 1'b1;
        if (!pend_vld_r) res = mk_status(STS_NONE);
      end
      default: ;
    endcase

    // Fresh scan on entry
    if (state_nxt == ST_SCAN && state_r != ST_SCAN) begin
      scan_addr_nxt = '0;
      free_found_nxt = 1'b0;
    end
  end

  // Worker table and backlog memories
  always_ff @(posedge clk) begin
    wk_q_r <= wk_mem[wk_raddr];
    if (wk_we) wk_mem[wk_waddr] <= wk_wdata;
  end

  always_ff @(posedge clk) begin
    bl_q_r <= bl_mem[head_r];
    if (bl_we) bl_mem[tail] <= bl_wdata;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wk_qv_r <= wk_vld_r[wk_raddr];
    stage_idx_r <= wk_raddr;
    free_idx_r <= free_idx_nxt;
    pick_w_r <= pick_w_nxt;
    pick_cnt_r <= pick_cnt_nxt;
    pend_r <= pend_nxt;
    scan_addr_r <= scan_addr_nxt;
    n_r <= n_nxt;
    if (load) out_r <= res;
    if (in_xfer) begin
      op_r   <= in_tuser[0];
      kind_r <= in_tuser[1];
      flow_r <= in_tdata[31:0];
      widx_r <= in_tdata[37:32];
      code_r <= in_tdata[53:38];
      ctx_r  <= in_tdata[85:54];
      tok_r  <= in_tdata[117:86];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      worker_count_r <= CFG_DW'(64);
      enabled_r <= 1'b0;
      wk_vld_r <= '0;
      head_r <= '0;
      fill_r <= '0;
      stage_r <= 1'b0;
      free_found_r <= 1'b0;
      pick_r <= PK_NONE;
      pend_vld_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_WORKER_COUNT: worker_count_r <= cfg_wdata;
          CFG_ENABLED:      enabled_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (wk_we) wk_vld_r[wk_waddr] <= 1'b1;
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      stage_r <= stage_nxt;
      free_found_r <= free_found_nxt;
      pick_r <= pick_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (load)            out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Output packing
  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_r.last;
  assign out_tuser  = {out_r.kind, out_r.status};
  assign out_tdata  = {2'b00, out_r.tok, out_r.ctx, out_r.code, out_r.flow, out_r.worker};

endmodule

>>> design/sidu_checker.sv
// Port-level checker for the flow-affinity dispatcher, bound to the top level.
`timescale 1ns / 1ps
`include "sync_id_affinity_dispatcher_unit_macros.svh"
module sidu_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sidu_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [sidu_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);
  import sidu_pkg::*;

  logic not_disp;
  logic single;
  assign not_disp = (out_tuser[2:0] != STS_DISPATCHED);
  assign single = (out_tuser[2:0] == STS_QUEUED) || (out_tuser[2:0] == STS_FULL) ||
                  (out_tuser[2:0] == STS_NONE) || (out_tuser[2:0] == STS_ERROR);

  // Non-dispatch results carry no worker, flow or kind
  `SIDU_ASSERT_NOW(a_nodisp_zero, clk, rst_n, out_tvalid && not_disp, out_tdata[37:0] == 38'd0 && !out_tuser[3])
  // Status-only results always close their item
  `SIDU_ASSERT_NOW(a_single_last, clk, rst_n, out_tvalid && single, out_tlast)
  // Block is busy right after taking an item
  `SIDU_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // Stalled result holds
  `SIDU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind sync_id_affinity_dispatcher_unit sidu_checker u_sidu_checker (.*);
